/* rtl/core/pqop_pkg.sv */
// shared types and codes for the overflow-policy priority queue
package pqop_pkg;

	localparam int STAMP_BITS = 32;
	localparam int COUNT_BITS = 32;
	localparam int FIELD_CNT_BITS = 5;
	localparam int CFG_DATA_BITS = 5;

	localparam logic [1:0] MODE_SUBMIT = 2'd0;
	localparam logic [1:0] MODE_TAKE   = 2'd1;
	localparam logic [1:0] MODE_CANCEL = 2'd2;

	localparam logic [2:0] POL_BLOCK       = 3'd0;
	localparam logic [2:0] POL_DROP_OLDEST = 3'd1;
	localparam logic [2:0] POL_DROP_LOWEST = 3'd2;
	localparam logic [2:0] POL_DROP_NEW    = 3'd3;
	localparam logic [2:0] POL_EXPAND      = 3'd4;

	localparam logic [2:0] ST_STORED    = 3'd0;
	localparam logic [2:0] ST_EVICTED   = 3'd1;
	localparam logic [2:0] ST_DROPPED   = 3'd2;
	localparam logic [2:0] ST_RETRY     = 3'd3;
	localparam logic [2:0] ST_TAKEN     = 3'd4;
	localparam logic [2:0] ST_EMPTY     = 3'd5;
	localparam logic [2:0] ST_CANCELLED = 3'd6;
	localparam logic [2:0] ST_NOT_FOUND = 3'd7;

	localparam logic CFG_CAPACITY = 1'b0;
	localparam logic CFG_POLICY   = 1'b1;

	typedef enum logic [1:0] {
		SK_OLDEST,
		SK_LOWEST,
		SK_HIGHEST,
		SK_CANCEL
	} search_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_APPLY
	} fsm_t;

	// best candidate so far, handed from cell to cell
	typedef struct packed {
		logic                  found;
		logic [STAMP_BITS-1:0] age;
		logic [1:0]            level;
		logic                  free_found;
	} cand_t;

	// entry update broadcast to all cells
	typedef struct packed {
		logic                  wr_en;
		logic                  clr_en;
		logic [1:0]            level;
		logic [STAMP_BITS-1:0] stamp;
	} upd_t;

endpackage

/* rtl/core/pqop_cell.sv */
// one queue entry plus its stage of the candidate search chain
module pqop_cell #(
	parameter int DEPTH = 16,
	parameter int TAG_BITS = 16,
	parameter int INDEX = 0,
	localparam int IW = $clog2(DEPTH)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [pqop_pkg::STAMP_BITS-1:0] arrival,
	input  pqop_pkg::search_t               sk,
	input  logic [TAG_BITS-1:0]             key_tag,
	input  pqop_pkg::upd_t                  upd,
	input  logic [IW-1:0]                   wr_idx,
	input  logic [IW-1:0]                   clr_idx,
	input  logic [TAG_BITS-1:0]             wr_tag,
	input  pqop_pkg::cand_t                 cand_in,
	input  logic [IW-1:0]                   cand_idx_in,
	input  logic [TAG_BITS-1:0]             cand_tag_in,
	input  logic [IW-1:0]                   free_idx_in,
	output pqop_pkg::cand_t                 cand_out,
	output logic [IW-1:0]                   cand_idx_out,
	output logic [TAG_BITS-1:0]             cand_tag_out,
	output logic [IW-1:0]                   free_idx_out
);

	logic                            valid_q;
	logic [TAG_BITS-1:0]             tag_q;
	logic [1:0]                      level_q;
	logic [pqop_pkg::STAMP_BITS-1:0] stamp_q;
	logic [pqop_pkg::STAMP_BITS-1:0] own_age;
	logic                            hit;
	logic                            better;
	logic                            take;
	logic                            own_free;
	pqop_pkg::cand_t                 cand_d;
	pqop_pkg::cand_t                 cand_q;
	logic [IW-1:0]                   cand_idx_q;
	logic [TAG_BITS-1:0]             cand_tag_q;
	logic [IW-1:0]                   free_idx_q;

	localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (upd.wr_en && wr_idx == MY_IDX) begin
			valid_q <= 1'b1;
		end else if (upd.clr_en && clr_idx == MY_IDX) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd.wr_en && wr_idx == MY_IDX) begin
			tag_q   <= wr_tag;
			level_q <= upd.level;
			stamp_q <= upd.stamp;
		end
	end

	assign own_age  = arrival - stamp_q;
	assign hit      = valid_q && (sk != pqop_pkg::SK_CANCEL || tag_q == key_tag);
	assign own_free = !valid_q && !cand_in.free_found;

	always_comb begin
		unique case (sk)
			pqop_pkg::SK_OLDEST,
			pqop_pkg::SK_CANCEL:  better = own_age > cand_in.age;
			pqop_pkg::SK_LOWEST:  better = level_q < cand_in.level ||
				(level_q == cand_in.level && own_age < cand_in.age);
			pqop_pkg::SK_HIGHEST: better = level_q > cand_in.level ||
				(level_q == cand_in.level && own_age > cand_in.age);
			default:              better = 1'b0;
		endcase
	end

	assign take = hit && (!cand_in.found || better);

	always_comb begin
		cand_d            = cand_in;
		cand_d.free_found = cand_in.free_found || !valid_q;
		if (take) begin
			cand_d.found = 1'b1;
			cand_d.age   = own_age;
			cand_d.level = level_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
		end else begin
			cand_q <= cand_d;
		end
	end

	always_ff @(posedge clk) begin
		cand_idx_q <= take ? MY_IDX : cand_idx_in;
		cand_tag_q <= take ? tag_q : cand_tag_in;
		free_idx_q <= own_free ? MY_IDX : free_idx_in;
	end

	assign cand_out     = cand_q;
	assign cand_idx_out = cand_idx_q;
	assign cand_tag_out = cand_tag_q;
	assign free_idx_out = free_idx_q;

endmodule

/* rtl/core/priority_queue_overflow_policy_unit.sv */
// Bounded priority queue with overflow policy. One word is handled at a time: after a word is
// accepted the entry search runs through a chain of DEPTH registered cells, one cell per cycle,
// so the result of a word is registered when the unit leaves APPLY, which waits while an earlier
// result is still held by out_stall; the next word is accepted as soon as the result is
// registered, even while it still waits on out_stall.
module priority_queue_overflow_policy_unit #(
	parameter int DEPTH = 16,
	parameter int TAG_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [pqop_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          mode,
	input  logic [TAG_BITS-1:0]                 task_tag,
	input  logic [1:0]                          prio_level,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [2:0]                          status,
	output logic [TAG_BITS-1:0]                 out_tag,
	output logic [1:0]                          out_level,
	output logic                                victim_valid,
	output logic [TAG_BITS-1:0]                 victim_tag,
	output logic [pqop_pkg::FIELD_CNT_BITS-1:0] occupancy,
	output logic [pqop_pkg::FIELD_CNT_BITS-1:0] peak_occupancy,
	output logic [pqop_pkg::COUNT_BITS-1:0]     dropped_total
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > pqop_pkg::FIELD_CNT_BITS) ? CW : pqop_pkg::FIELD_CNT_BITS;

	pqop_pkg::fsm_t                  state_q, state_d;
	logic [CW-1:0]                   scan_cnt_q;
	logic [4:0]                      cap_q;
	logic [2:0]                      policy_q;
	logic [1:0]                      mode_q;
	logic [TAG_BITS-1:0]             tag_q;
	logic [1:0]                      level_q;
	pqop_pkg::search_t               sk_q;
	logic [pqop_pkg::STAMP_BITS-1:0] arrival_q, arrival_d;
	logic [CW-1:0]                   held_q, held_d;
	logic [CW-1:0]                   peak_q;
	logic [pqop_pkg::COUNT_BITS-1:0] drop_q, drop_d;

	logic                            out_valid_q;
	logic [2:0]                      status_q, status_d;
	logic [TAG_BITS-1:0]             otag_q, otag_d;
	logic [1:0]                      olevel_q, olevel_d;
	logic                            vvalid_q, vvalid_d;
	logic [TAG_BITS-1:0]             vtag_q, vtag_d;

	pqop_pkg::cand_t                 cand [DEPTH+1];
	logic [IW-1:0]                   cand_idx [DEPTH+1];
	logic [TAG_BITS-1:0]             cand_tag [DEPTH+1];
	logic [IW-1:0]                   free_idx [DEPTH+1];

	pqop_pkg::upd_t                  upd;
	logic [IW-1:0]                   wr_idx, clr_idx;
	logic                            out_free;
	logic                            commit;
	logic                            in_acc;
	logic [XW-1:0]                   cap_x, held_x;
	pqop_pkg::cand_t                 fin;

	assign in_stall = state_q != pqop_pkg::FSM_IDLE;
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign commit   = state_q == pqop_pkg::FSM_APPLY && out_free;
	assign fin      = cand[DEPTH];

	// search chain
	assign cand[0]     = '0;
	assign cand_idx[0] = '0;
	assign cand_tag[0] = '0;
	assign free_idx[0] = '0;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		pqop_cell #(
			.DEPTH(DEPTH),
			.TAG_BITS(TAG_BITS),
			.INDEX(g)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.arrival(arrival_q),
			.sk(sk_q),
			.key_tag(tag_q),
			.upd(upd),
			.wr_idx(wr_idx),
			.clr_idx(clr_idx),
			.wr_tag(tag_q),
			.cand_in(cand[g]),
			.cand_idx_in(cand_idx[g]),
			.cand_tag_in(cand_tag[g]),
			.free_idx_in(free_idx[g]),
			.cand_out(cand[g+1]),
			.cand_idx_out(cand_idx[g+1]),
			.cand_tag_out(cand_tag[g+1]),
			.free_idx_out(free_idx[g+1])
		);
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= 5'd16;
			policy_q <= pqop_pkg::POL_BLOCK;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pqop_pkg::CFG_CAPACITY: cap_q <= cfg_data;
				pqop_pkg::CFG_POLICY:   policy_q <= cfg_data[2:0];
				default:                cap_q <= cap_q;
			endcase
		end
	end

	// latched request
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q  <= mode;
			tag_q   <= task_tag;
			level_q <= prio_level;
			priority case (mode)
				pqop_pkg::MODE_TAKE:   sk_q <= pqop_pkg::SK_HIGHEST;
				pqop_pkg::MODE_CANCEL: sk_q <= pqop_pkg::SK_CANCEL;
				default: sk_q <= (policy_q == pqop_pkg::POL_DROP_LOWEST) ?
					pqop_pkg::SK_LOWEST : pqop_pkg::SK_OLDEST;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pqop_pkg::FSM_IDLE;
			scan_cnt_q <= '0;
		end else begin
			state_q    <= state_d;
			scan_cnt_q <= (state_q == pqop_pkg::FSM_SCAN) ? scan_cnt_q + 1'b1 : '0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pqop_pkg::FSM_IDLE:  if (in_acc) state_d = pqop_pkg::FSM_SCAN;
			pqop_pkg::FSM_SCAN:  if (scan_cnt_q == CW'(DEPTH)) state_d = pqop_pkg::FSM_APPLY;
			pqop_pkg::FSM_APPLY: if (out_free) state_d = pqop_pkg::FSM_IDLE;
			default:             state_d = pqop_pkg::FSM_IDLE;
		endcase
	end

	// effective capacity
	always_comb begin
		cap_x  = XW'(cap_q);
		held_x = XW'(held_q);
		if (cap_x == '0) begin
			cap_x = XW'(1);
		end else if (cap_x > XW'(DEPTH)) begin
			cap_x = XW'(DEPTH);
		end
	end

	// policy decision on the search result
	always_comb begin
		upd        = '0;
		upd.level  = level_q;
		upd.stamp  = arrival_q;
		wr_idx     = fin.free_found ? free_idx[DEPTH] : cand_idx[DEPTH];
		clr_idx    = cand_idx[DEPTH];
		arrival_d  = arrival_q;
		held_d     = held_q;
		drop_d     = drop_q;
		status_d   = pqop_pkg::ST_NOT_FOUND;
		otag_d     = '0;
		olevel_d   = '0;
		vvalid_d   = 1'b0;
		vtag_d     = '0;
		priority case (mode_q)
			pqop_pkg::MODE_SUBMIT: begin
				priority if (held_x < cap_x || policy_q == pqop_pkg::POL_EXPAND) begin
					if (fin.free_found) begin
						upd.wr_en = 1'b1;
						arrival_d = arrival_q + 1'b1;
						held_d    = held_q + 1'b1;
						status_d  = pqop_pkg::ST_STORED;
					end else begin
						if (policy_q == pqop_pkg::POL_EXPAND) begin
							drop_d = drop_q + 1'b1;
						end
						status_d = pqop_pkg::ST_DROPPED;
					end
				end else if (policy_q == pqop_pkg::POL_BLOCK) begin
					status_d = pqop_pkg::ST_RETRY;
				end else if (policy_q == pqop_pkg::POL_DROP_OLDEST ||
					policy_q == pqop_pkg::POL_DROP_LOWEST) begin
					if (fin.found) begin
						// victim slot is reused for the new entry
						upd.wr_en = 1'b1;
						wr_idx    = cand_idx[DEPTH];
						arrival_d = arrival_q + 1'b1;
						drop_d    = drop_q + 1'b1;
						vvalid_d  = 1'b1;
						vtag_d    = cand_tag[DEPTH];
						status_d  = pqop_pkg::ST_EVICTED;
					end else begin
						status_d = pqop_pkg::ST_DROPPED;
					end
				end else if (policy_q == pqop_pkg::POL_DROP_NEW) begin
					drop_d   = drop_q + 1'b1;
					status_d = pqop_pkg::ST_DROPPED;
				end else begin
					status_d = pqop_pkg::ST_DROPPED;
				end
			end
			pqop_pkg::MODE_TAKE: begin
				if (fin.found) begin
					upd.clr_en = 1'b1;
					held_d     = held_q - 1'b1;
					otag_d     = cand_tag[DEPTH];
					olevel_d   = fin.level;
					status_d   = pqop_pkg::ST_TAKEN;
				end else begin
					status_d = pqop_pkg::ST_EMPTY;
				end
			end
			pqop_pkg::MODE_CANCEL: begin
				if (fin.found) begin
					upd.clr_en = 1'b1;
					held_d     = held_q - 1'b1;
					drop_d     = drop_q + 1'b1;
					status_d   = pqop_pkg::ST_CANCELLED;
				end
			end
			default: status_d = pqop_pkg::ST_NOT_FOUND;
		endcase
		if (!commit) begin
			upd.wr_en  = 1'b0;
			upd.clr_en = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arrival_q   <= '0;
			held_q      <= '0;
			peak_q      <= '0;
			drop_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				arrival_q   <= arrival_d;
				held_q      <= held_d;
				drop_q      <= drop_d;
				if (held_d > peak_q) begin
					peak_q <= held_d;
				end
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q <= status_d;
			otag_q   <= otag_d;
			olevel_q <= olevel_d;
			vvalid_q <= vvalid_d;
			vtag_q   <= vtag_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign out_tag        = otag_q;
	assign out_level      = olevel_q;
	assign victim_valid   = vvalid_q;
	assign victim_tag     = vtag_q;
	assign occupancy      = pqop_pkg::FIELD_CNT_BITS'(held_q);
	assign peak_occupancy = pqop_pkg::FIELD_CNT_BITS'(peak_q);
	assign dropped_total  = drop_q;

endmodule

/* rtl/core/pqop_checker.sv */
// port-level checks for the overflow-policy priority queue, bound to the top level
module pqop_checker #(
	parameter int TAG_BITS = 16
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [2:0]                          status,
	input logic [TAG_BITS-1:0]                 out_tag,
	input logic [1:0]                          out_level,
	input logic                                victim_valid,
	input logic [TAG_BITS-1:0]                 victim_tag,
	input logic [pqop_pkg::FIELD_CNT_BITS-1:0] occupancy,
	input logic [pqop_pkg::FIELD_CNT_BITS-1:0] peak_occupancy
);

	// one word in flight: the input closes right after a word is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted again without a gap");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("stalled result word changed");

	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> occupancy <= peak_occupancy)
		else $error("occupancy above peak");

	a_take_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != pqop_pkg::ST_TAKEN |-> out_tag == '0 && out_level == 2'd0)
		else $error("taken fields set on a non-take word");

	a_victim: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != pqop_pkg::ST_EVICTED |-> !victim_valid && victim_tag == '0)
		else $error("victim reported without eviction");

endmodule

bind priority_queue_overflow_policy_unit pqop_checker #(.TAG_BITS(TAG_BITS)) u_pqop_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.status(status),
	.out_tag(out_tag),
	.out_level(out_level),
	.victim_valid(victim_valid),
	.victim_tag(victim_tag),
	.occupancy(occupancy),
	.peak_occupancy(peak_occupancy)
);

/* bench/priority_queue_overflow_policy_unit_tb.sv */
// self-checking bench for the overflow-policy priority queue
module priority_queue_overflow_policy_unit_tb;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int SLOTS = 16;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] out_tag;
		logic [1:0]  out_level;
		logic        victim_valid;
		logic [15:0] victim_tag;
		logic [4:0]  occupancy;
		logic [4:0]  peak_occupancy;
		logic [31:0] dropped_total;
	} result_t;

	class queue_scoreboard;
		bit          slot_used[SLOTS];
		bit [15:0]   slot_tag[SLOTS];
		bit [1:0]    slot_level[SLOTS];
		bit [31:0]   slot_stamp[SLOTS];
		bit [31:0]   arrivals;
		bit [4:0]    held;
		bit [4:0]    peak;
		bit [31:0]   drops;
		bit [4:0]    capacity_reg = 5'd16;
		bit [2:0]    policy_reg = pqop_pkg::POL_BLOCK;
		result_t     pending[$];
		int          errors;

		function bit [31:0] age(int i);
			return arrivals - slot_stamp[i];
		endfunction

		function int pick(pqop_pkg::search_t kind, bit [15:0] t);
			int best;
			best = -1;
			for (int i = 0; i < SLOTS; i++) begin
				if (!slot_used[i]) continue;
				if (kind == pqop_pkg::SK_CANCEL && slot_tag[i] != t) continue;
				if (best < 0) begin
					best = i;
					continue;
				end
				case (kind)
					pqop_pkg::SK_OLDEST, pqop_pkg::SK_CANCEL: begin
						if (age(i) > age(best)) best = i;
					end
					pqop_pkg::SK_LOWEST: begin
						if (slot_level[i] < slot_level[best] ||
						    (slot_level[i] == slot_level[best] && age(i) < age(best)))
							best = i;
					end
					default: begin
						if (slot_level[i] > slot_level[best] ||
						    (slot_level[i] == slot_level[best] && age(i) > age(best)))
							best = i;
					end
				endcase
			end
			return best;
		endfunction

		function bit store(bit [15:0] t, bit [1:0] l);
			for (int i = 0; i < SLOTS; i++) begin
				if (!slot_used[i]) begin
					slot_used[i] = 1;
					slot_tag[i] = t;
					slot_level[i] = l;
					slot_stamp[i] = arrivals;
					arrivals++;
					held++;
					if (held > peak) peak = held;
					return 1;
				end
			end
			return 0;
		endfunction

		function void evict(int i);
			slot_used[i] = 0;
			if (held > 0) held--;
		endfunction

		function void note_word(bit [1:0] m, bit [15:0] t, bit [1:0] l);
			result_t r;
			int v;
			bit [4:0] c;
			r = '0;
			r.status = pqop_pkg::ST_NOT_FOUND;
			c = capacity_reg;
			if (c < 1) c = 1;
			if (c > SLOTS) c = SLOTS;
			case (m)
				pqop_pkg::MODE_SUBMIT: begin
					if (held < c) r.status = store(t, l) ? pqop_pkg::ST_STORED :
						pqop_pkg::ST_DROPPED;
					else case (policy_reg)
						pqop_pkg::POL_BLOCK: r.status = pqop_pkg::ST_RETRY;
						pqop_pkg::POL_DROP_OLDEST, pqop_pkg::POL_DROP_LOWEST: begin
							v = pick(policy_reg == pqop_pkg::POL_DROP_OLDEST ?
								pqop_pkg::SK_OLDEST : pqop_pkg::SK_LOWEST, t);
							if (v >= 0) begin
								r.victim_valid = 1;
								r.victim_tag = slot_tag[v];
								evict(v);
								drops++;
								void'(store(t, l));
								r.status = pqop_pkg::ST_EVICTED;
							end else r.status = pqop_pkg::ST_DROPPED;
						end
						pqop_pkg::POL_DROP_NEW: begin
							drops++;
							r.status = pqop_pkg::ST_DROPPED;
						end
						pqop_pkg::POL_EXPAND: begin
							if (store(t, l)) r.status = pqop_pkg::ST_STORED;
							else begin
								drops++;
								r.status = pqop_pkg::ST_DROPPED;
							end
						end
						default: r.status = pqop_pkg::ST_DROPPED;
					endcase
				end
				pqop_pkg::MODE_TAKE: begin
					v = pick(pqop_pkg::SK_HIGHEST, t);
					if (v >= 0) begin
						r.out_tag = slot_tag[v];
						r.out_level = slot_level[v];
						evict(v);
						r.status = pqop_pkg::ST_TAKEN;
					end else r.status = pqop_pkg::ST_EMPTY;
				end
				pqop_pkg::MODE_CANCEL: begin
					v = pick(pqop_pkg::SK_CANCEL, t);
					if (v >= 0) begin
						evict(v);
						drops++;
						r.status = pqop_pkg::ST_CANCELLED;
					end
				end
				default: r.status = pqop_pkg::ST_NOT_FOUND;
			endcase
			r.occupancy = held;
			r.peak_occupancy = peak;
			r.dropped_total = drops;
			pending.insert(pending.size(), r);
		endfunction

		function void check_word(result_t g);
			result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result word, status %0d", g.status);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (g.status != e.status) begin
				$error("status: expected %0d, got %0d", e.status, g.status);
				errors++;
			end
			if (g.out_tag != e.out_tag) begin
				$error("out_tag: expected %0h, got %0h", e.out_tag, g.out_tag);
				errors++;
			end
			if (g.out_level != e.out_level) begin
				$error("out_level: expected %0d, got %0d", e.out_level, g.out_level);
				errors++;
			end
			if (g.victim_valid != e.victim_valid) begin
				$error("victim_valid: expected %0d, got %0d", e.victim_valid, g.victim_valid);
				errors++;
			end
			if (g.victim_tag != e.victim_tag) begin
				$error("victim_tag: expected %0h, got %0h", e.victim_tag, g.victim_tag);
				errors++;
			end
			if (g.occupancy != e.occupancy) begin
				$error("occupancy: expected %0d, got %0d", e.occupancy, g.occupancy);
				errors++;
			end
			if (g.peak_occupancy != e.peak_occupancy) begin
				$error("peak_occupancy: expected %0d, got %0d", e.peak_occupancy,
					g.peak_occupancy);
				errors++;
			end
			if (g.dropped_total != e.dropped_total) begin
				$error("dropped_total: expected %0d, got %0d", e.dropped_total,
					g.dropped_total);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic        cfg_index = pqop_pkg::CFG_CAPACITY;
	logic [4:0]  cfg_data = '0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  mode = pqop_pkg::MODE_SUBMIT;
	logic [15:0] task_tag = '0;
	logic [1:0]  prio_level = '0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [2:0]  status;
	logic [15:0] out_tag;
	logic [1:0]  out_level;
	logic        victim_valid;
	logic [15:0] victim_tag;
	logic [4:0]  occupancy;
	logic [4:0]  peak_occupancy;
	logic [31:0] dropped_total;

	queue_scoreboard sb = new();
	bit quiet;
	bit hold_req;
	int idle_cycles;
	bit [15:0] tag_pool[6];

	priority_queue_overflow_policy_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .task_tag(task_tag), .prio_level(prio_level),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .out_tag(out_tag), .out_level(out_level),
		.victim_valid(victim_valid), .victim_tag(victim_tag),
		.occupancy(occupancy), .peak_occupancy(peak_occupancy),
		.dropped_total(dropped_total)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	task automatic send_word(logic [1:0] m, logic [15:0] t, logic [1:0] l);
		if (!quiet && $urandom_range(99) < 9) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1;
		mode <= m;
		task_tag <= t;
		prio_level <= l;
		do @(posedge clk); while (in_stall);
		sb.note_word(m, t, l);
	endtask

	task automatic random_word(int submit_pct);
		int r;
		logic [1:0] m;
		logic [15:0] t;
		r = $urandom_range(99);
		if (r < submit_pct) m = pqop_pkg::MODE_SUBMIT;
		else if (r < submit_pct + (100 - submit_pct) / 2) m = pqop_pkg::MODE_TAKE;
		else if (r < 96) m = pqop_pkg::MODE_CANCEL;
		else m = MODE_UNUSED;
		t = ($urandom_range(3) == 0) ? 16'($urandom) : tag_pool[$urandom_range(5)];
		send_word(m, t, 2'($urandom_range(3)));
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(logic [4:0] cap, logic [4:0] pol);
		cfg_we <= 1;
		cfg_index <= pqop_pkg::CFG_CAPACITY;
		cfg_data <= cap;
		@(posedge clk);
		cfg_index <= pqop_pkg::CFG_POLICY;
		cfg_data <= pol;
		@(posedge clk);
		cfg_we <= 0;
		sb.capacity_reg = cap;
		sb.policy_reg = pol[2:0];
	endtask

	// result side: check accepted words, then choose the next stall
	initial begin
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				sb.check_word('{status, out_tag, out_level, victim_valid, victim_tag,
					occupancy, peak_occupancy, dropped_total});
			if (hold_req) begin
				hold_req = 0;
				out_stall <= 1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_stall <= !quiet && ($urandom_range(99) < 9);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int caps[14] = '{1, 2, 0, 4, 16, 3, 31, 8, 17, 1, 5, 16, 2, 12};
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty queue, extremes, duplicates, unused mode
		send_word(pqop_pkg::MODE_TAKE, 16'h0000, 2'd0);
		send_word(pqop_pkg::MODE_CANCEL, 16'hffff, 2'd0);
		send_word(MODE_UNUSED, 16'h1234, 2'd3);
		send_word(pqop_pkg::MODE_SUBMIT, 16'h0000, 2'd0);
		send_word(pqop_pkg::MODE_SUBMIT, 16'hffff, 2'd3);
		send_word(pqop_pkg::MODE_SUBMIT, 16'h5a5a, 2'd1);
		send_word(pqop_pkg::MODE_SUBMIT, 16'h5a5a, 2'd2);
		send_word(pqop_pkg::MODE_SUBMIT, 16'ha5a5, 2'd3);
		send_word(pqop_pkg::MODE_CANCEL, 16'h5a5a, 2'd0);
		send_word(pqop_pkg::MODE_TAKE, 16'h0000, 2'd0);
		send_word(pqop_pkg::MODE_TAKE, 16'h0000, 2'd0);
		send_word(pqop_pkg::MODE_TAKE, 16'h0000, 2'd0);
		send_word(pqop_pkg::MODE_CANCEL, 16'h0000, 2'd0);
		send_word(pqop_pkg::MODE_CANCEL, 16'h0000, 2'd0);
		send_word(pqop_pkg::MODE_TAKE, 16'h0000, 2'd0);
		send_word(pqop_pkg::MODE_TAKE, 16'h0000, 2'd0);

		for (int p = 0; p < 14; p++) begin
			drain();
			write_regs(5'(caps[p]), 5'(p % 8));
			foreach (tag_pool[k]) tag_pool[k] = 16'($urandom);
			quiet = (p == 5);
			for (int n = 0; n < 110; n++) begin
				if (p == 3 && n == 40) hold_req = 1;
				if (p == 9 && n == 55) begin
					in_valid <= 0;
					while (sb.pending.size() != 0) @(posedge clk);
				end
				random_word((p % 8) == pqop_pkg::POL_EXPAND ? 75 : 60);
			end
		end

		drain();
		if (sb.errors == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end

endmodule
